@@ rtl/ntp_broadcast_server_tracker_top_macros.svh @@
// Assertion macros used by the tracker top-level RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef NTP_BROADCAST_SERVER_TRACKER_TOP_MACROS_SVH
`define NTP_BROADCAST_SERVER_TRACKER_TOP_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define NBST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define NBST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/nbst_pkg.sv @@
// Package for the NTP broadcast server tracker: word types, codes, constants.
// Depends on nothing.
package nbst_pkg;
  localparam int MaxServers = 8;
  localparam int SlotW = $clog2(MaxServers);
  localparam int CountW = $clog2(MaxServers + 1);

  localparam logic [9:0] HeaderBytes = 10'd48;
  localparam logic [2:0] ModeBroadcast = 3'd5;
  localparam logic [31:0] UnixEpochDelta = 32'd2208988800;
  localparam logic [19:0] UsPerSecond = 20'd1000000;

  localparam logic [2:0] RejNone = 3'd0;
  localparam logic [2:0] RejShort = 3'd1;
  localparam logic [2:0] RejMode = 3'd2;
  localparam logic [2:0] RejAuth = 3'd3;
  localparam logic [2:0] RejFull = 3'd4;

  localparam logic OpPacket = 1'b0;
  localparam logic OpSweep = 1'b1;

  localparam logic [0:0] RegRequireAuth = 1'b0;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_seconds;
    logic [31:0] source_address;
    logic [9:0]  packet_length;
    logic [7:0]  mode_byte;
    logic [7:0]  stratum_in;
    logic [31:0] reference_id;
    logic [31:0] transmit_seconds;
    logic [31:0] transmit_fraction;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  reject_code;
    logic [2:0]  slot;
    logic signed [31:0] srv_offset;
    logic [31:0] interval_seconds;
    logic [7:0]  reach_bits;
  } out_word_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  stratum;
    logic [31:0] reference;
    logic [31:0] last_seen;
    logic [31:0] interval;
    logic [7:0]  reach;
    logic        reachable;
    logic [31:0] offset;
  } entry_t;
endpackage

@@ rtl/nbst_offset.sv @@
// Offset unit: server minus local time in microseconds, two registered stages.
// Depends on nbst_pkg.
module nbst_offset (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] transmit_seconds,
  input  logic [31:0] transmit_fraction,
  input  logic [31:0] now_seconds,
  output logic [31:0] ofs_micro
);
  logic [31:0] sec_diff_r;
  logic [51:0] frac_prod_r;
  logic [31:0] offset_r;

  // Stage one: seconds difference and fraction scale; stage two: combine.
  // Only the low 32 bits survive, so the seconds product is kept mod 2^32.
  always_ff @(posedge clk) begin
    if (load) begin
      sec_diff_r  <= transmit_seconds - nbst_pkg::UnixEpochDelta - now_seconds;
      frac_prod_r <= 52'(transmit_fraction) * 52'(nbst_pkg::UsPerSecond);
    end
    offset_r <= 32'(sec_diff_r * 32'(nbst_pkg::UsPerSecond)) + 32'(frac_prod_r[51:32]);
  end

  assign ofs_micro = offset_r;
endmodule

@@ rtl/ntp_broadcast_server_tracker_top.sv @@
// Top level of the NTP broadcast server tracker: control, entry memory, APB port.
// Depends on nbst_pkg, nbst_offset and the assertion macro header.
`include "ntp_broadcast_server_tracker_top_macros.svh"
// A packet or sweep word is taken when start is high and busy is low; busy
// then stays high until the word is done. A packet gives exactly one result
// word on out_valid for a single cycle, which the receiver cannot stall; a
// sweep gives none. The entry table sits in one synchronous memory with a
// registered read, and the control walks it one entry per read, in two steps
// per entry (read, then compare). A packet that fails the header checks is
// rejected from the first busy state. A packet's work runs through the
// search, the read-modify-write, the two-stage offset unit and the output
// register; a full table rejects at the end of the search. The result word
// strobes in the same cycle as busy falls. A sweep walks the stored entries
// in the same read-then-check way. There is no clearing pass after reset: new
// entries are written in full when created, and only entries below the count
// are read.
module ntp_broadcast_server_tracker_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  nbst_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output nbst_pkg::out_word_t  out_word,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [1:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_UPD_RD, S_UPD, S_OFS1, S_OFS2, S_OUT,
    S_WRD, S_WCHK
  } state_t;

  state_t state_r;
  nbst_pkg::in_word_t item_r;
  logic require_auth_r;
  logic [nbst_pkg::CountW-1:0] count_r;
  logic [nbst_pkg::CountW-1:0] idx_r;
  logic found_r;
  logic out_valid_r;
  nbst_pkg::out_word_t out_r;

  // Entry memory, one read and one write port.
  nbst_pkg::entry_t mem [nbst_pkg::MaxServers];
  nbst_pkg::entry_t rd_q;
  logic [nbst_pkg::SlotW-1:0] rd_addr;
  logic we;
  logic [nbst_pkg::SlotW-1:0] wr_addr;
  nbst_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Load the offset unit from the held word in each S_SRD state of a packet.
  logic [31:0] ofs_val;
  nbst_offset u_offset (
    .clk              (clk),
    .load             (state_r == S_SRD),
    .transmit_seconds (item_r.transmit_seconds),
    .transmit_fraction(item_r.transmit_fraction),
    .now_seconds      (item_r.now_seconds),
    .ofs_micro        (ofs_val)
  );

  // Configuration port: write at access phase, with pready tied high.
  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == {nbst_pkg::RegRequireAuth, 1'b0}) ?
                      {31'd0, require_auth_r} : 32'd0;

  // Packet checks on the held word.
  logic [2:0] chk_code;
  always_comb begin
    if (item_r.packet_length < nbst_pkg::HeaderBytes) begin
      chk_code = nbst_pkg::RejShort;
    end else if (item_r.mode_byte[2:0] != nbst_pkg::ModeBroadcast) begin
      chk_code = nbst_pkg::RejMode;
    end else if (require_auth_r && item_r.packet_length <= nbst_pkg::HeaderBytes) begin
      chk_code = nbst_pkg::RejAuth;
    end else begin
      chk_code = nbst_pkg::RejNone;
    end
  end

  logic [nbst_pkg::SlotW-1:0] slot;
  assign slot = idx_r[nbst_pkg::SlotW-1:0];

  // Entry update, computed from the read entry.
  nbst_pkg::entry_t upd;
  logic [31:0] sample;
  logic [34:0] avg;
  logic [33:0] three_iv;
  logic stale;
  always_comb begin
    sample = item_r.now_seconds - rd_q.last_seen;
    avg = ({3'd0, rd_q.interval} << 3) - {3'd0, rd_q.interval} + {3'd0, sample};
    three_iv = {2'd0, rd_q.interval} + {1'd0, rd_q.interval, 1'b0};
    stale = {2'd0, sample} > three_iv;
    upd = rd_q;
    if (!found_r) begin
      upd = '0;
      upd.address = item_r.source_address;
    end
    upd.stratum = item_r.stratum_in;
    upd.reference = item_r.reference_id;
    if (found_r) begin
      upd.interval = (rd_q.interval == 32'd0) ? sample : avg[34:3];
    end
    upd.last_seen = item_r.now_seconds;
    upd.reach = {upd.reach[6:0], 1'b1};
    upd.reachable = 1'b1;
  end

  always_comb begin
    rd_addr = slot;
    we = 1'b0;
    wr_addr = slot;
    wr_data = upd;
    if (state_r == S_UPD) begin
      we = 1'b1;
    end else if (state_r == S_OFS2) begin
      // Write the offset from the offset unit back into the same entry.
      we = 1'b1;
      wr_data = rd_q;
      wr_data.offset = ofs_val;
    end else if (state_r == S_WCHK && stale) begin
      we = 1'b1;
      wr_data = rd_q;
      wr_data.reach = {rd_q.reach[6:0], 1'b0};
      if (rd_q.reach[6:0] == 7'd0) begin
        wr_data.reachable = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      require_auth_r <= 1'b0;
      count_r <= '0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      found_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr && cfg_paddr == {nbst_pkg::RegRequireAuth, 1'b0}) begin
        require_auth_r <= cfg_pwdata[0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r <= in_word;
            idx_r <= '0;
            found_r <= 1'b0;
            state_r <= (in_word.operation == nbst_pkg::OpSweep) ? S_WRD : S_SRD;
          end
        end
        S_SRD: begin
          // Reject now, or search (address already issued).
          if (chk_code != nbst_pkg::RejNone) begin
            out_r <= '{accepted: 1'b0, reject_code: chk_code, slot: 3'd0,
                       srv_offset: 32'sd0, interval_seconds: 32'd0, reach_bits: 8'd0};
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else if (idx_r == count_r) begin
            if (count_r == nbst_pkg::CountW'(nbst_pkg::MaxServers)) begin
              out_r <= '{accepted: 1'b0, reject_code: nbst_pkg::RejFull, slot: 3'd0,
                         srv_offset: 32'sd0, interval_seconds: 32'd0, reach_bits: 8'd0};
              out_valid_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              count_r <= count_r + nbst_pkg::CountW'(1);
              state_r <= S_UPD_RD;
            end
          end else begin
            state_r <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (rd_q.address == item_r.source_address) begin
            found_r <= 1'b1;
            state_r <= S_UPD;
          end else begin
            idx_r <= idx_r + nbst_pkg::CountW'(1);
            state_r <= S_SRD;
          end
        end
        S_UPD_RD: state_r <= S_UPD;
        S_UPD: begin
          out_r <= '{accepted: 1'b1, reject_code: nbst_pkg::RejNone, slot: 3'(slot),
                     srv_offset: 32'sd0, interval_seconds: upd.interval,
                     reach_bits: upd.reach};
          state_r <= S_OFS1;
        end
        S_OFS1: state_r <= S_OFS2;
        S_OFS2: begin
          out_r.srv_offset <= ofs_val;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_WRD: state_r <= (idx_r == count_r) ? S_IDLE : S_WCHK;
        S_WCHK: begin
          idx_r <= idx_r + nbst_pkg::CountW'(1);
          state_r <= S_WRD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word = out_r;

  `NBST_ASSERT_IMP(a_count_range, 1'b1, count_r <= nbst_pkg::CountW'(nbst_pkg::MaxServers))
  `NBST_ASSERT_IMP(a_idx_range, busy, idx_r <= count_r)
  `NBST_ASSERT_NEXT(a_out_one_cycle, out_valid_r, !out_valid_r)
  `NBST_ASSERT_IMP(a_out_idle, out_valid_r, state_r == S_IDLE)
endmodule
